[hw/rtl/pc_sample_histogram_assert.svh]
// ---------------------------------------------------------------------------
// pc sample histogram assertion macros
// concurrent checks, clocked on clk and held off during rst
// ---------------------------------------------------------------------------
`ifndef PC_SAMPLE_HISTOGRAM_ASSERT_SVH
`define PC_SAMPLE_HISTOGRAM_ASSERT_SVH

// same-cycle implication
`define PCSH_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PCSH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/pcsh_pkg.sv]
// ---------------------------------------------------------------------------
// pcsh_pkg
// shared types and codes of the pc sample histogram
// ---------------------------------------------------------------------------
package pcsh_pkg;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned SHIFT_W = 5;
  localparam int unsigned LIMIT_W = 11;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned INDEX_W = 10;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned CFG_W   = 2;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  // register indexes
  localparam logic [CFG_W-1:0] REG_RANGE_START  = 2'd0;
  localparam logic [CFG_W-1:0] REG_SIZE_LOG2    = 2'd1;
  localparam logic [CFG_W-1:0] REG_BUCKET_LIMIT = 2'd2;

  // register reset values
  localparam logic [ADDR_W-1:0]  RANGE_START_RST  = 32'h4000_0000;
  localparam logic [SHIFT_W-1:0] SIZE_LOG2_RST    = 5'd0;
  localparam logic [LIMIT_W-1:0] BUCKET_LIMIT_RST = 11'd1024;

  typedef struct packed {
    logic [ADDR_W-1:0]  range_start;
    logic [SHIFT_W-1:0] size_log2;
    logic [LIMIT_W-1:0] bucket_limit;
  } pcsh_cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0] bucket;     // sample bucket, full width
    logic              sample_in;  // sample bucket below the limit
    logic              index_in;   // read index below the limit
    logic [ADDR_W-1:0] base_addr;  // base address of the read index
  } pcsh_map_t;

endpackage

[hw/rtl/pcsh_in_if.sv]
// ---------------------------------------------------------------------------
// pcsh_in_if
// item channel into the histogram: sample, read or clear words
// ---------------------------------------------------------------------------
interface pcsh_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] pc;
  logic [9:0]  bucket_index;

  modport source (output valid, kind, pc, bucket_index, input ready);
  modport sink   (input valid, kind, pc, bucket_index, output ready);
endinterface

[hw/rtl/pcsh_out_if.sv]
// ---------------------------------------------------------------------------
// pcsh_out_if
// result channel out of the histogram: one word per read
// ---------------------------------------------------------------------------
interface pcsh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] bucket_addr;
  logic [31:0] bucket_hits;
  logic [31:0] sample_total;
  logic [31:0] outside_total;
  logic        index_in_range;

  modport source (output valid, bucket_addr, bucket_hits, sample_total, outside_total,
                  index_in_range, input ready);
  modport sink   (input valid, bucket_addr, bucket_hits, sample_total, outside_total,
                  index_in_range, output ready);
endinterface

[hw/rtl/pcsh_addr_map.sv]
// ---------------------------------------------------------------------------
// pcsh_addr_map
// maps a pc to its bucket and a read index to its base address
// ---------------------------------------------------------------------------
module pcsh_addr_map #(
  parameter int unsigned BUCKETS = 1024
) (
  input  pcsh_pkg::pcsh_cfg_t              cfg,
  input  logic [pcsh_pkg::ADDR_W-1:0]      pc,
  input  logic [pcsh_pkg::INDEX_W-1:0]     bucket_index,
  output pcsh_pkg::pcsh_map_t              map
);
  import pcsh_pkg::*;

  localparam logic [ADDR_W-1:0] DEPTH = ADDR_W'(BUCKETS);

  logic [ADDR_W-1:0] limit_ext;
  logic [ADDR_W-1:0] limit_eff;
  logic [ADDR_W-1:0] offset;
  logic [ADDR_W-1:0] index_ext;

  always_comb begin
    limit_ext = {{(ADDR_W-LIMIT_W){1'b0}}, cfg.bucket_limit};
    // limit saturates at the store depth
    limit_eff = (limit_ext > DEPTH) ? DEPTH : limit_ext;
    offset    = pc - cfg.range_start;
    index_ext = {{(ADDR_W-INDEX_W){1'b0}}, bucket_index};

    map.bucket    = offset >> cfg.size_log2;
    map.sample_in = map.bucket < limit_eff;
    map.index_in  = index_ext < limit_eff;
    map.base_addr = cfg.range_start + (index_ext << cfg.size_log2);
  end

endmodule

[hw/rtl/pc_sample_histogram.sv]
// ---------------------------------------------------------------------------
// pc_sample_histogram
// program counter sampling histogram over a synchronous bucket store
// ---------------------------------------------------------------------------
// sample: a read then a write-back of one bucket entry
// read: the store is read on acceptance, then ST_READ loads the result register
// read: held in ST_READ while the previous result is still unclaimed
// clear: one store entry zeroed per cycle, counters zeroed on acceptance
// rst runs the same clearing pass before any word is taken
// config registers return to their reset values on rst; config writes taken outside rst
module pc_sample_histogram #(
  parameter int unsigned BUCKETS = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  pcsh_in_if.sink                      req,
  pcsh_out_if.source                   rsp,
  input  logic                         cfg_we,
  input  logic [pcsh_pkg::CFG_W-1:0]   cfg_index,
  input  logic [pcsh_pkg::ADDR_W-1:0]  cfg_data
);
  import pcsh_pkg::*;

  `include "pc_sample_histogram_assert.svh"

  // store index width, at least one bit
  localparam int unsigned AW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam logic [AW-1:0] LAST_ENTRY = AW'(BUCKETS - 1);

  // sequencer states
  localparam logic [1:0] ST_CLEAR = 2'd0;  // sweeping the store with zeros
  localparam logic [1:0] ST_IDLE  = 2'd1;  // ready for the next word
  localparam logic [1:0] ST_RMW   = 2'd2;  // write back an incremented bucket
  localparam logic [1:0] ST_READ  = 2'd3;  // load the result register

  // configuration registers
  pcsh_cfg_t cfg;

  // sequencer
  logic [1:0]    state;
  logic [AW-1:0] clr_addr;

  // running counters
  logic [COUNT_W-1:0] total_count;
  logic [COUNT_W-1:0] outside_count;

  // held across the states of an item
  logic [AW-1:0]     hold_idx;
  logic              hold_hit;
  logic              hold_inr;
  logic [ADDR_W-1:0] hold_base;

  // bucket store
  logic [COUNT_W-1:0] store [BUCKETS];
  logic [COUNT_W-1:0] rdata;
  logic               rd_en;
  logic [AW-1:0]      raddr;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [COUNT_W-1:0] wdata;

  // result register
  logic               out_valid;
  logic [ADDR_W-1:0]  out_addr;
  logic [COUNT_W-1:0] out_hits;
  logic [COUNT_W-1:0] out_total;
  logic [COUNT_W-1:0] out_outside;
  logic               out_inr;

  pcsh_map_t         map;
  logic              accept;
  logic [ADDR_W-1:0] index_ext;

  pcsh_addr_map #(
    .BUCKETS (BUCKETS)
  ) u_map (
    .cfg          (cfg),
    .pc           (req.pc),
    .bucket_index (req.bucket_index),
    .map          (map)
  );

  // one word at a time; the result register lets the next word in early
  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign index_ext = {{(ADDR_W-INDEX_W){1'b0}}, req.bucket_index};

  // store read port: the bucket of a sample or the index of a read
  always_comb begin
    rd_en = accept && ((req.kind == KIND_SAMPLE) || (req.kind == KIND_READ));
    raddr = (req.kind == KIND_READ) ? index_ext[AW-1:0] : map.bucket[AW-1:0];
  end

  // store write port: zero sweep, or increment of the held bucket
  always_comb begin
    we    = (state == ST_CLEAR) || ((state == ST_RMW) && hold_hit);
    waddr = (state == ST_CLEAR) ? clr_addr : hold_idx;
    wdata = (state == ST_CLEAR) ? '0 : rdata + COUNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= store[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
  end

  // configuration writes; an index beyond the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.range_start  <= RANGE_START_RST;
      cfg.size_log2    <= SIZE_LOG2_RST;
      cfg.bucket_limit <= BUCKET_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RANGE_START:  cfg.range_start  <= cfg_data;
        REG_SIZE_LOG2:    cfg.size_log2    <= cfg_data[SHIFT_W-1:0];
        REG_BUCKET_LIMIT: cfg.bucket_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_addr      <= '0;
      total_count   <= '0;
      outside_count <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_ENTRY) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            unique case (req.kind)
              KIND_SAMPLE: begin
                total_count <= total_count + COUNT_W'(1);
                if (!map.sample_in) begin
                  outside_count <= outside_count + COUNT_W'(1);
                end
                state <= ST_RMW;
              end
              KIND_READ: begin
                state <= ST_READ;
              end
              KIND_CLEAR: begin
                total_count   <= '0;
                outside_count <= '0;
                clr_addr      <= '0;
                state         <= ST_CLEAR;
              end
              default: ;  // unused kind, dropped
            endcase
          end
        end
        ST_RMW: begin
          state <= ST_IDLE;
        end
        ST_READ: begin
          // wait here while the previous result is still unclaimed
          if (!out_valid || rsp.ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // per-item holding registers, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      hold_idx  <= map.bucket[AW-1:0];
      hold_hit  <= (req.kind == KIND_SAMPLE) && map.sample_in;
      hold_inr  <= map.index_in;
      hold_base <= map.base_addr;
    end
  end

  // result register; totals cannot move while a read is in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_READ) && (!out_valid || rsp.ready)) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_READ) && (!out_valid || rsp.ready)) begin
      out_addr    <= hold_base;
      out_hits    <= hold_inr ? rdata : '0;
      out_total   <= total_count;
      out_outside <= outside_count;
      out_inr     <= hold_inr;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.bucket_addr    = out_addr;
  assign rsp.bucket_hits    = out_hits;
  assign rsp.sample_total   = out_total;
  assign rsp.outside_total  = out_outside;
  assign rsp.index_in_range = out_inr;

  // checks
  `PCSH_ASSERT_SAME(a_no_accept_in_clear, state == ST_CLEAR, !req.ready,
    "word accepted during clearing sweep")
  `PCSH_ASSERT_NEXT(a_sample_counts, accept && (req.kind == KIND_SAMPLE),
    total_count == $past(total_count) + COUNT_W'(1), "sample total did not advance")
  `PCSH_ASSERT_NEXT(a_clear_zeroes, accept && (req.kind == KIND_CLEAR),
    (state == ST_CLEAR) && (total_count == '0) && (outside_count == '0),
    "clear did not zero the counters")
  `PCSH_ASSERT_SAME(a_outside_hits_zero, rsp.valid && !rsp.index_in_range,
    rsp.bucket_hits == '0, "hits reported for an index beyond the limit")

endmodule

[sim/tb.sv]
// ---------------------------------------------------------------------------
// tb
// testbench of the pc sample histogram: a directed script, then random phases
// that each set the range registers and send sample, read and clear words.
// every read result is checked field by field against a predicted or typed-in result.
// ---------------------------------------------------------------------------
module tb;
  import pcsh_pkg::*;

  localparam int unsigned BUCKETS     = 1024;
  // settle time before a register write: a clear may still be sweeping the store
  localparam int unsigned SETTLE      = BUCKETS + 16;
  // watchdog: cycles with no word accepted on either channel
  localparam int unsigned STALL_LIMIT = 10000;
  // receiver hold-off used to back the block up
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned PHASES      = 10;
  localparam int unsigned PHASE_WORDS = 65;

  // kind code the block must ignore
  localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd3;
  // register index past the end of the register list
  localparam logic [CFG_W-1:0]  REG_NONE     = 2'd3;

  // one read result, in the order of the result channel fields
  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [COUNT_W-1:0] hits;
    logic [COUNT_W-1:0] total;
    logic [COUNT_W-1:0] outside;
    logic               inr;
  } read_word_t;

  // one row of the directed script: a register write or an input word
  typedef struct packed {
    logic               is_setting;
    logic [CFG_W-1:0]   reg_idx;
    logic [31:0]        data;      // register value, or pc of a word
    logic [KIND_W-1:0]  kind;
    logic [INDEX_W-1:0] idx;
    logic               known;     // typed-in result below, not predicted
    read_word_t         want;
  } script_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_W-1:0]  cfg_index;
  logic [ADDR_W-1:0] cfg_data;

  pcsh_in_if  req_if ();
  pcsh_out_if rsp_if ();

  pc_sample_histogram #(
    .BUCKETS (BUCKETS)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_if),
    .rsp       (rsp_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predicted histogram state and register copies
  logic [COUNT_W-1:0] hist [BUCKETS];
  logic [COUNT_W-1:0] total_cnt;
  logic [COUNT_W-1:0] outside_cnt;
  logic [ADDR_W-1:0]  cur_start;
  logic [SHIFT_W-1:0] cur_shift;
  logic [LIMIT_W-1:0] cur_limit;

  read_word_t  pending_reads [$];   // predicted read results, oldest first
  script_row_t script [$];
  int unsigned errors;
  int unsigned hold_asks;           // bumped to ask the receiver for a long hold-off
  bit          sender_calm;         // no gaps between input words
  bit          dirty;               // words accepted since the last settle
  logic [INDEX_W-1:0] hot_bucket;   // last bucket aimed at, read back often

  // clock, period 2
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // predictor
  // -------------------------------------------------------------------------

  function automatic void clear_histo();
    foreach (hist[i]) hist[i] = '0;
    total_cnt   = '0;
    outside_cnt = '0;
  endfunction

  // applies one accepted word to the predicted state; returns 1 when the word
  // gives a result, which is then left in res
  function automatic bit histo_apply(input logic [KIND_W-1:0] k, input logic [31:0] p,
                                     input logic [INDEX_W-1:0] ix, output read_word_t res);
    logic [31:0] bucket;
    logic [31:0] lim;
    lim = (cur_limit > BUCKETS) ? BUCKETS : 32'(cur_limit);   // limit saturates at depth
    res = '0;
    case (k)
      KIND_SAMPLE: begin
        bucket = (p - cur_start) >> cur_shift;   // offset wraps mod 2^32
        if (bucket < lim) hist[bucket] += 1;
        else outside_cnt += 1;
        total_cnt += 1;
      end
      KIND_READ: begin
        res.addr    = cur_start + (32'(ix) << cur_shift);
        res.inr     = (32'(ix) < lim);
        res.hits    = res.inr ? hist[ix] : '0;   // out-of-range read reports no hits
        res.total   = total_cnt;
        res.outside = outside_cnt;
        return 1'b1;
      end
      KIND_CLEAR: clear_histo();
      default: ;                                 // unknown kind: no effect
    endcase
    return 1'b0;
  endfunction

  // -------------------------------------------------------------------------
  // stimulus helpers
  // -------------------------------------------------------------------------

  function automatic script_row_t row_item(input logic [KIND_W-1:0] k, input logic [31:0] p,
                                           input logic [INDEX_W-1:0] ix);
    script_row_t r;
    r = '0;
    r.kind = k;
    r.data = p;
    r.idx  = ix;
    return r;
  endfunction

  function automatic script_row_t row_read_known(input logic [INDEX_W-1:0] ix,
                                                 input read_word_t w);
    script_row_t r;
    r = row_item(KIND_READ, 32'h0, ix);
    r.known = 1'b1;
    r.want  = w;
    return r;
  endfunction

  function automatic script_row_t row_setting(input logic [CFG_W-1:0] ri, input logic [31:0] v);
    script_row_t r;
    r = '0;
    r.is_setting = 1'b1;
    r.reg_idx    = ri;
    r.data       = v;
    return r;
  endfunction

  // gap before a word: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (sender_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // offers one word and holds it until the block takes it
  task automatic send_word(input logic [KIND_W-1:0] k, input logic [31:0] p,
                           input logic [INDEX_W-1:0] ix, input logic known,
                           input read_word_t want);
    read_word_t predicted;
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) repeat (gap) @(negedge clk);
    req_if.valid        = 1'b1;
    req_if.kind         = k;
    req_if.pc           = p;
    req_if.bucket_index = ix;
    do @(posedge clk); while (!req_if.ready);
    if (histo_apply(k, p, ix, predicted)) pending_reads.push_back(known ? want : predicted);
    dirty = 1'b1;
    @(negedge clk);
    req_if.valid = 1'b0;
  endtask

  // register write, only once the block has gone quiet
  task automatic write_setting(input logic [CFG_W-1:0] ri, input logic [31:0] v);
    if (dirty) begin
      while (pending_reads.size() != 0) @(negedge clk);
      repeat (SETTLE) @(negedge clk);
      dirty = 1'b0;
    end
    cfg_we    = 1'b1;
    cfg_index = ri;
    cfg_data  = v;
    case (ri)
      REG_RANGE_START:  cur_start = v;
      REG_SIZE_LOG2:    cur_shift = v[SHIFT_W-1:0];
      REG_BUCKET_LIMIT: cur_limit = v[LIMIT_W-1:0];
      default: ;                                  // no such register
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // directed script: extremes, wrap-around of the offset, the ignored kind,
  // clear, a zero limit, a limit above the depth, the largest shift and a
  // write to a register index that does not exist
  task automatic build_script();
    script.push_back(row_read_known(10'd0,    '{32'h4000_0000, 32'd0, 32'd0, 32'd0, 1'b1}));
    script.push_back(row_read_known(10'd1023, '{32'h4000_03FF, 32'd0, 32'd0, 32'd0, 1'b1}));
    script.push_back(row_item(KIND_SAMPLE, 32'h4000_0000, 10'd0));
    script.push_back(row_item(KIND_SAMPLE, 32'h4000_0000, 10'h3FF));
    script.push_back(row_item(KIND_SAMPLE, 32'h4000_03FF, 10'd0));
    script.push_back(row_item(KIND_SAMPLE, 32'h4000_0400, 10'd0));    // one past the top
    script.push_back(row_item(KIND_SAMPLE, 32'h3FFF_FFFF, 10'd0));    // below start, wraps
    script.push_back(row_item(KIND_SAMPLE, 32'hFFFF_FFFF, 10'd0));
    script.push_back(row_item(KIND_SAMPLE, 32'h0000_0000, 10'd0));
    script.push_back(row_item(KIND_IGNORED, 32'h4000_0000, 10'h3FF));
    script.push_back(row_read_known(10'd0,    '{32'h4000_0000, 32'd2, 32'd7, 32'd4, 1'b1}));
    script.push_back(row_read_known(10'd1023, '{32'h4000_03FF, 32'd1, 32'd7, 32'd4, 1'b1}));
    script.push_back(row_item(KIND_READ, 32'h5555_5555, 10'd5));
    script.push_back(row_item(KIND_CLEAR, 32'hFFFF_FFFF, 10'h3FF));
    script.push_back(row_read_known(10'd0,    '{32'h4000_0000, 32'd0, 32'd0, 32'd0, 1'b1}));
    script.push_back(row_item(KIND_SAMPLE, 32'h4000_0001, 10'd0));
    script.push_back(row_item(KIND_READ, 32'h0, 10'd1));
    script.push_back(row_setting(REG_BUCKET_LIMIT, 32'd0));            // all samples outside
    script.push_back(row_item(KIND_SAMPLE, 32'h4000_0000, 10'd0));
    script.push_back(row_item(KIND_READ, 32'h0, 10'd0));
    script.push_back(row_setting(REG_BUCKET_LIMIT, 32'd2047));         // saturates at depth
    script.push_back(row_item(KIND_SAMPLE, 32'h4000_03FF, 10'd0));
    script.push_back(row_item(KIND_READ, 32'h0, 10'd1023));
    script.push_back(row_setting(REG_SIZE_LOG2, 32'd31));
    script.push_back(row_setting(REG_RANGE_START, 32'hFFFF_FFFF));
    script.push_back(row_setting(REG_NONE, 32'h1234_5678));
    script.push_back(row_item(KIND_SAMPLE, 32'h7FFF_FFFF, 10'd0));
    script.push_back(row_item(KIND_SAMPLE, 32'hFFFF_FFFE, 10'd0));
    script.push_back(row_item(KIND_READ, 32'h0, 10'd1));
    script.push_back(row_item(KIND_READ, 32'h0, 10'd1023));
  endtask

  // register values for one random phase; phases 0 and 1 pin the extremes, 2 and 3 other values
  task automatic set_phase_registers(input int unsigned ph);
    int unsigned r;
    logic [31:0] start_v;
    logic [31:0] shift_v;
    logic [31:0] limit_v;
    r = $urandom_range(0, 3);
    start_v = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
    shift_v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 8);
    case ($urandom_range(0, 5))
      0:       limit_v = 32'd0;
      1:       limit_v = 32'd1;
      2:       limit_v = BUCKETS;
      3:       limit_v = $urandom_range(BUCKETS + 1, 2047);
      4:       limit_v = $urandom_range(1, 64);
      default: limit_v = $urandom_range(1, BUCKETS);
    endcase
    case (ph)
      0: begin start_v = 32'h0;         shift_v = 0;  limit_v = 1;    end
      1: begin start_v = 32'hFFFF_FFFF; shift_v = 31; limit_v = 2047; end
      2: begin                          shift_v = 2;  limit_v = 16;   end
      3: begin
        start_v = RANGE_START_RST;
        shift_v = 32'(SIZE_LOG2_RST);
        limit_v = 32'(BUCKET_LIMIT_RST);
      end
      default: ;
    endcase
    write_setting(REG_RANGE_START, start_v);
    write_setting(REG_SIZE_LOG2, shift_v);
    write_setting(REG_BUCKET_LIMIT, limit_v);
  endtask

  // one random word, aimed mostly at buckets in and just past the range
  task automatic send_random_word(output bit counted);
    int unsigned r;
    int unsigned lim;
    logic [31:0] b;
    logic [31:0] p;
    logic [INDEX_W-1:0] ix;
    logic [KIND_W-1:0]  k;
    lim = (cur_limit > BUCKETS) ? BUCKETS : 32'(cur_limit);
    r = $urandom_range(0, 99);
    k = (r < 55) ? KIND_SAMPLE : (r < 90) ? KIND_READ : (r < 93) ? KIND_CLEAR : KIND_IGNORED;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      b = $urandom_range(0, lim + 1);
      p = cur_start + (b << cur_shift) + ($urandom & ((32'h1 << cur_shift) - 1));
      if (b < BUCKETS && k == KIND_SAMPLE) hot_bucket = b[INDEX_W-1:0];
    end else if (r < 85) begin
      p = $urandom;
    end else begin
      p = cur_start - $urandom_range(1, 4);          // just below the range start
    end
    r = $urandom_range(0, 99);
    if (r < 50) ix = hot_bucket;
    else if (r < 80) ix = INDEX_W'($urandom_range(0, BUCKETS - 1));
    else ix = (lim == 0) ? 10'd0 : (lim >= BUCKETS) ? 10'(BUCKETS - 1)
                                 : 10'(lim - $urandom_range(0, 1));
    send_word(k, p, ix, 1'b0, '0);
    counted = (k != KIND_IGNORED);
  endtask

  // -------------------------------------------------------------------------
  // main sequence
  // -------------------------------------------------------------------------
  initial begin
    script_row_t row;
    bit counted;
    int unsigned words;
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    req_if.valid        = 1'b0;
    req_if.kind         = '0;
    req_if.pc           = '0;
    req_if.bucket_index = '0;
    errors      = 0;
    hold_asks   = 0;
    sender_calm = 1'b0;
    dirty       = 1'b1;         // the clearing pass after reset counts as busy
    hot_bucket  = '0;
    cur_start   = RANGE_START_RST;
    cur_shift   = SIZE_LOG2_RST;
    cur_limit   = BUCKET_LIMIT_RST;
    clear_histo();
    build_script();
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // directed part
    foreach (script[i]) begin
      row = script[i];
      if (row.is_setting) write_setting(row.reg_idx, row.data);
      else send_word(row.kind, row.data, row.idx, row.known, row.want);
    end

    // random phases; the first backs the block up behind a held result channel
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      set_phase_registers(ph);
      sender_calm = (ph % 3 == 0);
      if (ph == 0) hold_asks++;
      words = 0;
      while (words < PHASE_WORDS) begin
        send_random_word(counted);
        if (counted) words++;
      end
    end

    // drain, then let any stray result show up
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // -------------------------------------------------------------------------
  // result channel: ready pattern with short and long holds, plus the long
  // hold-off on request, counted here in cycles
  // -------------------------------------------------------------------------
  initial begin
    int unsigned run;
    int unsigned hold_left;
    int unsigned holds_done;
    int unsigned r;
    logic level;
    run        = 0;
    hold_left  = 0;
    holds_done = 0;
    level      = 1'b0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done != hold_asks) begin
        holds_done = hold_asks;
        hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready = 1'b0;
      end else begin
        if (run == 0) begin
          r = $urandom_range(0, 99);
          if (r < 10) begin level = 1'b1; run = $urandom_range(100, 200); end
          else if (r < 65) begin level = 1'b1; run = $urandom_range(1, 30); end
          else if (r < 92) begin level = 1'b0; run = $urandom_range(1, 3); end
          else begin level = 1'b0; run = $urandom_range(8, 40); end
        end
        rsp_if.ready = level;
        run--;
      end
    end
  end

  // -------------------------------------------------------------------------
  // checker: each accepted result word against the oldest prediction
  // -------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    read_word_t got;
    read_word_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      got = '{rsp_if.bucket_addr, rsp_if.bucket_hits, rsp_if.sample_total,
              rsp_if.outside_total, rsp_if.index_in_range};
      if (pending_reads.size() == 0) begin
        $display("%0t: unexpected result expected none got %h", $time, got);
        errors++;
      end else begin
        want = pending_reads.pop_front();
        check_field("bucket_addr",    want.addr,    got.addr);
        check_field("bucket_hits",    want.hits,    got.hits);
        check_field("sample_total",   want.total,   got.total);
        check_field("outside_total",  want.outside, got.outside);
        check_field("index_in_range", 32'(want.inr), 32'(got.inr));
      end
    end
  end

  // -------------------------------------------------------------------------
  // watchdog: too long with no word moving on either channel
  // -------------------------------------------------------------------------
  int unsigned quiet_cycles;

  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no word accepted for %0d cycles", $time, quiet_cycles);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/pcsh_pkg.sv
hw/rtl/pcsh_in_if.sv
hw/rtl/pcsh_out_if.sv
hw/rtl/pcsh_addr_map.sv
hw/rtl/pc_sample_histogram.sv
sim/tb.sv
